[design/isf_pkg.sv]
// Shared types and constants of the input shaping tap filter.
package isf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int TAP_IDX_W  = 2;
  localparam int NUM_TAP_REGS = 4;

  // signed sample times zero-extended gain
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  // four products summed
  localparam int ACC_W  = PROD_W + 2;
  localparam int FRAC_BITS = 15;

  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  localparam logic [GAIN_W-1:0] TAP0_GAIN_RESET = 16'd32768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP0_GAIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2_GAIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP3_GAIN  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0_DELAY = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1_DELAY = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2_DELAY = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TAP3_DELAY = 4'd7;

  // controller to datapath commands
  typedef struct packed {
    logic                 write;     // store incoming word into the delay line
    logic                 clear;     // zero the accumulator
    logic                 read;      // issue a tap read
    logic [TAP_IDX_W-1:0] tap;       // tap being read
    logic                 mul;       // multiply the returned tap
    logic                 acc;       // add the product into the accumulator
    logic                 load_out;  // floor-shift, clip, load output word, advance
  } isf_cmd_t;

endpackage

[design/isf_in_if.sv]
// Input channel: one command sample word per handshake.
interface isf_in_if import isf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] command_sample;

  modport source (output valid, output command_sample, input ready);
  modport sink   (input valid, input command_sample, output ready);
endinterface

[design/isf_out_if.sv]
// Output channel: one shaped sample word per handshake.
interface isf_out_if import isf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] shaped_sample;
  logic                       saturated;

  modport source (output valid, output shaped_sample, output saturated, input ready);
  modport sink   (input valid, input shaped_sample, input saturated, output ready);
endinterface

[design/isf_ram.sv]
// Generic single-port RAM with registered read data.
module isf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/isf_ctrl.sv]
// Sequencer: accept, tap reads, pipeline drain and output hand-off.
module isf_ctrl import isf_pkg::*; #(
  parameter int TAP_COUNT = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output isf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAP_COUNT - 1);

  logic [1:0]           state, state_next;
  logic [TAP_IDX_W-1:0] tap_cnt, tap_cnt_next;
  logic                 rd_d1, rd_d2;
  logic                 accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    tap_cnt_next = tap_cnt;
    cmd          = '0;
    cmd.tap      = tap_cnt;
    cmd.mul      = rd_d1;
    cmd.acc      = rd_d2;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.write    = 1'b1;
          cmd.clear    = 1'b1;
          tap_cnt_next = '0;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        cmd.read = 1'b1;
        if (tap_cnt == LAST_TAP) begin
          state_next = S_DRAIN;
        end else begin
          tap_cnt_next = tap_cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        // last product is being summed this cycle once the multiply stage is empty
        if (!rd_d1) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_cnt   <= '0;
      rd_d1     <= 1'b0;
      rd_d2     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      tap_cnt <= tap_cnt_next;
      rd_d1   <= cmd.read;
      rd_d2   <= rd_d1;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/isf_datapath.sv]
// Tap registers, delay line, multiply-accumulate and output stage.
module isf_datapath import isf_pkg::*; #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  isf_cmd_t                   cmd,
  input  logic signed [SAMPLE_W-1:0] command_sample,
  output logic signed [SAMPLE_W-1:0] shaped_sample,
  output logic                       saturated
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int RK    = DELAY_W + AW;
  localparam longint RECIP = ((64'(1) << RK) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int PW    = 2 * DELAY_W + 1;
  localparam int QW    = DELAY_W + AW + 1;
  localparam int SH_W  = ACC_W - FRAC_BITS;

  // delay modulo depth by reciprocal multiply plus one correction
  function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] d);
    logic [PW-1:0]      prod;
    logic [DELAY_W-1:0] q;
    logic [QW-1:0]      rem;
    prod = PW'(d) * PW'(RECIP);
    q    = DELAY_W'(prod >> RK);
    rem  = QW'(d) - QW'(q) * QW'(HISTORY_DEPTH);
    if (rem >= QW'(HISTORY_DEPTH)) begin
      rem = rem - QW'(HISTORY_DEPTH);
    end
    return AW'(rem);
  endfunction

  logic [GAIN_W-1:0] gain   [NUM_TAP_REGS];
  logic [AW-1:0]     delay  [NUM_TAP_REGS];
  logic [AW-1:0]     pos;
  logic [AW-1:0]     fill;     // samples held before the current one, saturating
  logic [AW-1:0]     dsel;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic              tap_valid;
  logic [GAIN_W-1:0] gain_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   shifted;
  logic signed [SAMPLE_W-1:0] clip;
  logic                     clip_flag;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain[0] <= TAP0_GAIN_RESET;
      gain[1] <= '0;
      gain[2] <= '0;
      gain[3] <= '0;
      for (int i = 0; i < NUM_TAP_REGS; i++) begin
        delay[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP0_GAIN:  gain[0]  <= cfg_data[GAIN_W-1:0];
        REG_TAP1_GAIN:  gain[1]  <= cfg_data[GAIN_W-1:0];
        REG_TAP2_GAIN:  gain[2]  <= cfg_data[GAIN_W-1:0];
        REG_TAP3_GAIN:  gain[3]  <= cfg_data[GAIN_W-1:0];
        REG_TAP0_DELAY: delay[0] <= reduce_delay(cfg_data[DELAY_W-1:0]);
        REG_TAP1_DELAY: delay[1] <= reduce_delay(cfg_data[DELAY_W-1:0]);
        REG_TAP2_DELAY: delay[2] <= reduce_delay(cfg_data[DELAY_W-1:0]);
        REG_TAP3_DELAY: delay[3] <= reduce_delay(cfg_data[DELAY_W-1:0]);
        default: ;
      endcase
    end
  end

  // tap address
  assign dsel = delay[cmd.tap];
  always_comb begin
    if (pos >= dsel) begin
      slot = pos - dsel;
    end else begin
      slot = AW'((AW+1)'(pos) + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(dsel));
    end
  end
  assign ram_addr = cmd.write ? pos : slot;

  isf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (cmd.write),
    .addr  (ram_addr),
    .wdata (command_sample),
    .rdata (ram_rdata)
  );

  // slots never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      tap_valid <= (dsel <= fill);
      gain_q    <= gain[cmd.tap];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (tap_valid) begin
        prod <= $signed(ram_rdata) * $signed({1'b0, gain_q});
      end else begin
        prod <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc <= '0;
    end else if (cmd.acc) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor shift and clip
  always_comb begin
    shifted   = SH_W'(acc >>> FRAC_BITS);
    clip      = SAMPLE_W'(shifted);
    clip_flag = 1'b0;
    if (shifted > $signed(SH_W'(SAMPLE_MAX))) begin
      clip      = SAMPLE_W'(SAMPLE_MAX);
      clip_flag = 1'b1;
    end else if (shifted < $signed(SH_W'(SAMPLE_MIN))) begin
      clip      = SAMPLE_W'(SAMPLE_MIN);
      clip_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      shaped_sample <= clip;
      saturated     <= clip_flag;
    end
  end

  // write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
    end else if (cmd.load_out) begin
      pos <= (pos == AW'(HISTORY_DEPTH - 1)) ? '0 : pos + 1'b1;
      if (fill != AW'(HISTORY_DEPTH - 1)) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

[design/input_shaping_tap_filter_unit.sv]
// Top level of the input shaping tap filter: controller plus datapath.
// Usage:
//   command : sink channel, one signed 24-bit command sample word per handshake.
//   shaped  : source channel, one shaped sample word plus a saturated flag for
//             every accepted command word, in order.
//   cfg_we/cfg_index/cfg_data : write-only register port, written while idle.
//             Indexes 0..3 are tap gains (unsigned Q1.15), 4..7 tap delays in
//             sample steps; other indexes are ignored.
// Timing:
//   A word is accepted only when the sequencer is idle. The sample is written
//   into the delay-line RAM in the accept cycle, then one tap read per cycle
//   follows on the single RAM port, a two-stage multiply/accumulate drains,
//   and a final step floor-shifts and clips into the output register. The next
//   word is taken only after that load, once the sequencer is idle again.
// Reset: clears the write pointer, the fill count, the output valid and the tap
//   registers to a unity first tap; delay-line slots not yet written read as
//   zero through the fill count, so no clearing pass is needed.
// Stall: a finished word waits in the output register; the next command word is
//   still taken and worked, and only its final load waits for shaped.ready.
module input_shaping_tap_filter_unit import isf_pkg::*; #(
  parameter int HISTORY_DEPTH = 1024,
  parameter int TAP_COUNT     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  isf_in_if.sink                command,
  isf_out_if.source             shaped
);

  isf_cmd_t cmd;

  // sequencer: owns all handshake state and the tap counter
  isf_ctrl #(
    .TAP_COUNT (TAP_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (command.valid),
    .in_ready  (command.ready),
    .out_valid (shaped.valid),
    .out_ready (shaped.ready),
    .cmd       (cmd)
  );

  // datapath: registers, delay line, MAC and output word
  isf_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .command_sample (command.command_sample),
    .shaped_sample  (shaped.shaped_sample),
    .saturated      (shaped.saturated)
  );

endmodule

[verif/input_shaping_tap_filter_unit_tb.sv]
// Self-checking bench for the input shaping tap filter: random taps, sample streams, stalls.
module input_shaping_tap_filter_unit_tb;
  import isf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 1024;
  localparam int TAPS       = 4;
  // settling wait after the last drain, before the final verdict
  localparam int SETTLE_CYCLES = TAPS + 3 + 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT_WORD = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS = 60;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

  localparam logic signed [SAMPLE_W-1:0] WORD_MAX  = SAMPLE_W'(SAMPLE_MAX);
  localparam logic signed [SAMPLE_W-1:0] WORD_MIN  = SAMPLE_W'(SAMPLE_MIN);
  localparam logic signed [SAMPLE_W-1:0] WORD_ZERO = '0;
  localparam logic signed [SAMPLE_W-1:0] WORD_ONE  = SAMPLE_W'(1);
  localparam logic signed [SAMPLE_W-1:0] WORD_NEG1 = '1;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sat;
  } shaped_word_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // Tap filter predictor plus the queue of shaped words still owed by the block.
  class shaper_scoreboard;
    logic [SAMPLE_W-1:0] history [HIST_DEPTH];
    int                  wr_pos;
    logic [GAIN_W-1:0]   gain [NUM_TAP_REGS];
    logic [DELAY_W-1:0]  delay [NUM_TAP_REGS];
    shaped_word_t        owed_q[$];
    int                  mismatches;
    int                  seen;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_pos = 0;
      gain[0] = TAP0_GAIN_RESET;
      for (int t = 1; t < NUM_TAP_REGS; t++) gain[t] = '0;
      foreach (delay[t]) delay[t] = '0;
      mismatches = 0;
      seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TAP0_GAIN:  gain[0] = data;
        REG_TAP1_GAIN:  gain[1] = data;
        REG_TAP2_GAIN:  gain[2] = data;
        REG_TAP3_GAIN:  gain[3] = data;
        REG_TAP0_DELAY: delay[0] = data[DELAY_W-1:0];
        REG_TAP1_DELAY: delay[1] = data[DELAY_W-1:0];
        REG_TAP2_DELAY: delay[2] = data[DELAY_W-1:0];
        REG_TAP3_DELAY: delay[3] = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    // store the command word, sum the taps, floor-shift and clip
    function void take_command(logic signed [SAMPLE_W-1:0] cmd);
      longint       acc;
      longint       res;
      int           slot;
      shaped_word_t w;
      history[wr_pos] = cmd;
      acc = 0;
      for (int t = 0; t < TAPS && t < NUM_TAP_REGS; t++) begin
        slot = (wr_pos + HIST_DEPTH - (int'(delay[t]) % HIST_DEPTH)) % HIST_DEPTH;
        acc += longint'($signed(history[slot])) * longint'(gain[t]);
      end
      res = acc >>> FRAC_BITS;
      w.sat = 1'b0;
      if (res > SAMPLE_MAX) begin
        res = SAMPLE_MAX;
        w.sat = 1'b1;
      end else if (res < SAMPLE_MIN) begin
        res = SAMPLE_MIN;
        w.sat = 1'b1;
      end
      w.sample = res[SAMPLE_W-1:0];
      owed_q.insert(owed_q.size(), w);
      wr_pos = (wr_pos + 1) % HIST_DEPTH;
    endfunction

    function void check_shaped(logic [SAMPLE_W-1:0] got_sample, logic got_sat);
      shaped_word_t w;
      seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("shaped word %0d arrived with nothing owed: %0d sat %0b",
                   seen, $signed(got_sample), got_sat);
        return;
      end
      w = owed_q.pop_front();
      if (got_sample !== w.sample || got_sat !== w.sat) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("shaped word %0d: expected %0d sat %0b, got %0d sat %0b", seen,
                   $signed(w.sample), w.sat, $signed(got_sample), got_sat);
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    function int failures();
      return mismatches + owed_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  isf_in_if  cmd_if ();
  isf_out_if shaped_if ();

  shaper_scoreboard model = new();

  // receiver behavior, changed between phases
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_period = 5;
  logic     hold_off;

  int words_in = 0;
  int walk = 0;

  input_shaping_tap_filter_unit #(
    .HISTORY_DEPTH (HIST_DEPTH),
    .TAP_COUNT     (TAPS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (cmd_if),
    .shaped    (shaped_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: checks every accepted shaped word, then picks next cycle's ready.
  // Values are read before this edge's updates land, so the checked word is
  // the one the block saw taken.
  initial begin : shaped_sink
    int cnt;
    shaped_if.ready = 1'b0;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && shaped_if.valid && shaped_if.ready)
        model.check_shaped(shaped_if.shaped_sample, shaped_if.saturated);
      cnt = (cnt + 1) % rx_period;
      case (rx_mode)
        RX_OPEN:     shaped_if.ready <= !hold_off;
        RX_RANDOM:   shaped_if.ready <= !hold_off && ($urandom_range(0, 3) != 0);
        // low while the window count is at most a third of the period
        RX_PERIODIC: shaped_if.ready <= !hold_off && (cnt > rx_period / 3);
        RX_SPARSE:   shaped_if.ready <= !hold_off && ($urandom_range(0, 3) == 0);
        default:     shaped_if.ready <= !hold_off;
      endcase
    end
  end

  // One long receiver hold-off in the middle of a busy phase: the sender keeps
  // offering, the output register and the word behind it fill, input stalls.
  initial begin : rx_hold_off
    hold_off = 1'b0;
    wait (words_in >= HOLD_OFF_AT_WORD);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Writes a batch of registers on back-to-back cycles; we stays high across
  // the batch so it is never dropped and raised in one step.
  task automatic program_regs(input reg_write_t writes[$]);
    foreach (writes[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= writes[i].idx;
      cfg_data  <= writes[i].data;
      @(posedge clk);
      model.write_reg(writes[i].idx, writes[i].data);
    end
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of random length, random gaps between them (none when
  // gap_max is zero). Each word is noted as accepted at the handshake edge.
  task automatic send_words(input logic signed [SAMPLE_W-1:0] words[$], input int gap_max);
    int burst;
    burst = $urandom_range(1, 16);
    foreach (words[i]) begin
      cmd_if.valid          <= 1'b1;
      cmd_if.command_sample <= words[i];
      do @(posedge clk); while (!cmd_if.ready);
      model.take_command(words[i]);
      words_in++;
      burst--;
      if (i == words.size() - 1) begin
        cmd_if.valid <= 1'b0;
      end else if (burst == 0 && gap_max > 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic drain();
    while (model.owed() != 0) @(posedge clk);
  endtask

  // Command stream: mostly a random walk (realistic motion commands), with
  // full-range noise and rail values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] next_word();
    int pick;
    int span;
    int v;
    logic [SAMPLE_W-1:0] raw;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      span = (pick < 6) ? 255 : 65535;
      v = walk + int'($urandom_range(0, 2 * span)) - span;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    end else if (pick < 17) begin
      raw = SAMPLE_W'($urandom);
      v = $signed(raw);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = SAMPLE_MAX;
        1:       v = SAMPLE_MIN;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    walk = v;
    return v[SAMPLE_W-1:0];
  endfunction

  // Tap settings: shaper-like (gains sum to unity, rising delays), fully
  // random, rail values, or sparse taps. Delay writes carry junk in the
  // bits above the register width; sometimes a write to an unused index.
  task automatic random_config();
    reg_write_t         writes[$];
    reg_write_t         w;
    logic [GAIN_W-1:0]  g [NUM_TAP_REGS];
    logic [DELAY_W-1:0] d [NUM_TAP_REGS];
    logic [5:0]         junk;
    int                 kind;
    int                 left;
    int                 nd;
    kind = $urandom_range(0, 3);
    left = 32768;
    for (int t = 0; t < NUM_TAP_REGS; t++) begin
      case (kind)
        0: begin
          g[t] = (t == NUM_TAP_REGS - 1) ? GAIN_W'(left) : GAIN_W'($urandom_range(0, left));
          left -= int'(g[t]);
          nd = (t == 0) ? $urandom_range(0, 3) : int'(d[t-1]) + $urandom_range(1, 40);
          d[t] = (nd > 1023) ? 10'd1023 : nd[DELAY_W-1:0];
        end
        1: begin
          g[t] = GAIN_W'($urandom_range(0, 65535));
          d[t] = DELAY_W'($urandom_range(0, 1023));
        end
        2: begin
          case ($urandom_range(0, 3))
            0:       g[t] = 16'd0;
            1:       g[t] = 16'd1;
            2:       g[t] = 16'd32768;
            default: g[t] = 16'd65535;
          endcase
          case ($urandom_range(0, 3))
            0:       d[t] = 10'd0;
            1:       d[t] = 10'd1;
            2:       d[t] = 10'd1022;
            default: d[t] = 10'd1023;
          endcase
        end
        default: begin
          g[t] = ($urandom_range(0, 1) != 0) ? 16'd0 : GAIN_W'($urandom_range(0, 40000));
          d[t] = DELAY_W'($urandom_range(0, 15));
        end
      endcase
    end
    for (int t = 0; t < NUM_TAP_REGS; t++) begin
      w.idx  = CFG_IDX_W'(int'(REG_TAP0_GAIN) + t);
      w.data = g[t];
      writes.insert(writes.size(), w);
    end
    for (int t = 0; t < NUM_TAP_REGS; t++) begin
      junk   = 6'($urandom);
      w.idx  = CFG_IDX_W'(int'(REG_TAP0_DELAY) + t);
      w.data = {junk, d[t]};
      writes.insert(writes.size(), w);
    end
    if ($urandom_range(0, 2) == 0) begin
      w.idx  = CFG_IDX_W'($urandom_range(int'(REG_TAP3_DELAY) + 1, int'(REG_INDEX_TOP)));
      w.data = CFG_DATA_W'($urandom);
      if ($urandom_range(0, 1) != 0) writes.insert(0, w);
      else writes.insert(writes.size(), w);
    end
    program_regs(writes);
  endtask

  initial begin : main
    logic signed [SAMPLE_W-1:0] words[$];
    reg_write_t                 regs[$];
    int                         gap_tab [RANDOM_PHASES];
    rx_mode_e                   rx_tab [RANDOM_PHASES];

    gap_tab = '{0, 3, 2, 12, 24, 3, 0, 6};
    rx_tab  = '{RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE,
                RX_RANDOM, RX_PERIODIC, RX_SPARSE, RX_OPEN};

    cmd_if.valid          = 1'b0;
    cmd_if.command_sample = '0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset taps pass samples straight through: rails and bit patterns.
    words = '{WORD_ZERO, WORD_MAX, WORD_MIN, WORD_NEG1, WORD_ONE, 24'h555555, 24'hAAAAAA};
    send_words(words, 0);
    drain();

    // All gains at full scale, delays 0, 1, 2, 1023: saturation both ways,
    // the longest delay reads a slot never written. Two delay writes carry high
    // junk bits; two writes go to indexes past the register map.
    regs = '{'{REG_TAP0_GAIN, 16'hFFFF}, '{REG_TAP1_GAIN, 16'hFFFF},
             '{REG_TAP2_GAIN, 16'hFFFF}, '{REG_TAP3_GAIN, 16'hFFFF},
             '{REG_TAP0_DELAY, 16'h0000}, '{REG_TAP1_DELAY, 16'hFC01},
             '{REG_TAP2_DELAY, 16'h0002}, '{REG_TAP3_DELAY, 16'hFFFF},
             '{REG_TAP3_DELAY + 4'd1, 16'h1234}, '{REG_INDEX_TOP, 16'hFFFF}};
    program_regs(regs);
    words = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN,
              WORD_MIN, WORD_ZERO, WORD_NEG1, WORD_ONE, WORD_MAX};
    send_words(words, 2);
    drain();

    // Every tap unused: output must be zero whatever the history holds.
    regs = '{'{REG_TAP0_GAIN, 16'h0000}, '{REG_TAP1_GAIN, 16'h0000},
             '{REG_TAP2_GAIN, 16'h0000}, '{REG_TAP3_GAIN, 16'h0000}};
    program_regs(regs);
    words = '{WORD_MIN, WORD_MAX};
    send_words(words, 0);
    drain();

    // Random phases: fresh taps, a new stream and a new receiver pattern each;
    // long delays mostly read slots not yet written.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      rx_mode   <= rx_tab[p];
      rx_period <= $urandom_range(3, 11);
      words.delete();
      for (int i = 0; i < PHASE_WORDS; i++) words.insert(words.size(), next_word());
      send_words(words, gap_tab[p]);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.failures() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
